@@ src/vssp_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the variable-speed sample player: field widths,
// stream packing offsets, item kinds and configuration register indexes.
// No dependencies.
package vssp_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SPEED_W  = 24;
    localparam int GAIN_W   = 16;
    localparam int KIND_W   = 2;

    localparam int SLEN_W   = 17;
    localparam int BLEN_W   = 13;
    localparam int BCNT_W   = 12;
    localparam int BLEN_MAX = 4096;

    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;

    localparam int ADDR_IN_W   = 16;
    localparam int ADDR_LSB    = 0;
    localparam int SAMPLE_LSB  = 16;
    localparam int TARGET_LSB  = 32;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 16;

    localparam int MIX_W = 35;

    localparam logic [KIND_W-1:0] KIND_PLAY_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RENDER    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOP_LOAD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_ENABLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCRATCH_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_GAIN     = 3'd5;

endpackage

@@ src/variable_speed_sample_player_core.sv @@
`timescale 1ns / 1ps
// Variable-speed sample player: play and loop stores, ramped Q16.16 position,
// linear interpolation and optional two-gain mix. Uses vssp_pkg, vssp_store, vssp_div.
//
// Usage:
//  s_ channel carries one item per transfer: tuser is the kind (play load,
//  render, loop load); tdata holds address, sample and target speed.
//  Load items write their store at the transfer edge.
//  Each render item returns one transfer on the m_ channel: tdata is the
//  output sample, tlast marks the last sample of a block.
//  The position wrap runs the divider when the position lands more than one
//  store length outside range. One item is worked at a time: s_tready is
//  high only while idle.
//  The result register frees the engine: a new item is taken while a result
//  waits; a render stalls in its output state while the receiver holds off.
//  Reset (aresetn low, synchronous) clears position, speed, ramp, counters and
//  m_tvalid, and loads config defaults; store contents stay undefined until written.
//  Configuration writes are taken on any cycle with cfg_wr_en high.
module variable_speed_sample_player_core #(
    parameter int ADDR_BITS  = 16,
    parameter int FRAC_BITS  = 16,
    parameter int RAMP_STEPS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // address[15:0], sample_value[31:16], speed_goal[55:32]
    input  logic [vssp_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [vssp_pkg::KIND_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_sample[15:0]
    output logic [vssp_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [vssp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vssp_pkg::CFG_W-1:0]      cfg_wdata
);
    import vssp_pkg::*;

    localparam int P  = ADDR_BITS + FRAC_BITS;
    localparam int VW = P + 1;
    localparam int LW = ADDR_BITS + 1;
    localparam int CW = (LW > SLEN_W) ? LW : SLEN_W;
    localparam int SW = ((P > SPEED_W) ? P : SPEED_W) + 3;
    localparam int DW = SW - 1;
    localparam int PW = FRAC_BITS + SAMPLE_W + 2;
    localparam int RW = SPEED_W + 1;
    localparam int AW = SPEED_W + 2;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_PREP   = 13'b0000000000010,
        ST_RDIV   = 13'b0000000000100,
        ST_RAMP   = 13'b0000000001000,
        ST_POS    = 13'b0000000010000,
        ST_PDIV   = 13'b0000000100000,
        ST_READ_A = 13'b0000001000000,
        ST_READ_B = 13'b0000010000000,
        ST_MULT   = 13'b0000100000000,
        ST_INTERP = 13'b0001000000000,
        ST_MIX    = 13'b0010000000000,
        ST_SAT    = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [SLEN_W-1:0] sample_length_reg;
    logic [BLEN_W-1:0] block_length_reg;
    logic [SLEN_W-1:0] loop_length_reg;
    logic              mix_enable_reg;
    logic [GAIN_W-1:0] scratch_gain_reg;
    logic [GAIN_W-1:0] loop_gain_reg;

    // playback state
    logic [P-1:0]                pos_reg, pos_next;
    logic signed [SPEED_W-1:0]   cur_speed_reg, cur_speed_next;
    logic signed [SPEED_W-1:0]   latched_reg, latched_next;
    logic signed [RW-1:0]        step_reg, step_next;
    logic [BCNT_W-1:0]           bc_reg, bc_next;
    logic [ADDR_BITS-1:0]        lp_reg, lp_next;
    logic                        m_tvalid_reg, m_tvalid_next;

    // payload
    logic signed [SPEED_W-1:0]   tgt_reg;
    logic                        sign_reg;
    logic signed [SAMPLE_W-1:0]  sa_reg;
    logic signed [PW-1:0]        p0_reg, p1_reg;
    logic signed [MIX_W-1:0]     m0_reg, m1_reg;
    logic signed [SAMPLE_W-1:0]  res_reg;
    logic [M_TDATA_W-1:0]        m_tdata_reg;
    logic                        m_tlast_reg;

    logic              s_xfer;
    logic [KIND_W-1:0] in_kind;
    logic [ADDR_BITS-1:0] in_addr;
    logic [SAMPLE_W-1:0]  in_sample;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign in_kind   = s_tuser;
    assign in_addr   = ADDR_BITS'(s_tdata[ADDR_LSB +: ADDR_IN_W]);
    assign in_sample = s_tdata[SAMPLE_LSB +: SAMPLE_W];

    // clamped lengths
    logic [CW-1:0] len_hi, sl_x, ll_x, slen_c, llen_c;
    logic [LW-1:0] slen, llen;
    logic [BLEN_W-1:0] blen;
    logic [VW-1:0] m_len;

    always_comb begin
        len_hi = CW'(1) << ADDR_BITS;
        sl_x   = CW'(sample_length_reg);
        ll_x   = CW'(loop_length_reg);
        if (sl_x == '0) begin
            slen_c = CW'(1);
        end else if (sl_x > len_hi) begin
            slen_c = len_hi;
        end else begin
            slen_c = sl_x;
        end
        if (ll_x == '0) begin
            llen_c = CW'(1);
        end else if (ll_x > len_hi) begin
            llen_c = len_hi;
        end else begin
            llen_c = ll_x;
        end
        if (block_length_reg == '0) begin
            blen = BLEN_W'(1);
        end else if (block_length_reg > BLEN_W'(BLEN_MAX)) begin
            blen = BLEN_W'(BLEN_MAX);
        end else begin
            blen = block_length_reg;
        end
    end

    assign slen  = slen_c[LW-1:0];
    assign llen  = llen_c[LW-1:0];
    assign m_len = {slen, {FRAC_BITS{1'b0}}};

    // position wrap divider
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [VW-1:0] div_divisor;
    logic          div_done;
    logic [VW-1:0] div_rem;

    vssp_div #(
        .DW(DW),
        .VW(VW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // ramp; step = |diff| / RAMP_STEPS by reciprocal multiply, exact for RW-bit inputs
    localparam int     RSH   = RW + $clog2(RAMP_STEPS);
    localparam int     KW    = RW + 1;
    localparam longint RECIP = ((longint'(1) << RSH) + longint'(RAMP_STEPS) - 1)
                             / longint'(RAMP_STEPS);

    logic signed [RW-1:0] r_diff;
    logic [RW-1:0]        r_mag;
    logic                 r_change;
    logic signed [AW-1:0] r_sum, r_lat;
    logic [RW-1:0]        mag_reg;
    logic [RW+KW-1:0]     r_prod;
    logic [RW-1:0]        r_quo;

    assign r_diff   = RW'(tgt_reg) - RW'(cur_speed_reg);
    assign r_mag    = r_diff[RW-1] ? RW'(-r_diff) : RW'(r_diff);
    assign r_change = (tgt_reg != latched_reg);
    assign r_sum    = AW'(cur_speed_reg) + AW'(step_reg);
    assign r_lat    = AW'(latched_reg);
    assign r_prod   = mag_reg * KW'(RECIP);
    assign r_quo    = RW'(r_prod >> RSH);

    // position wrap
    logic signed [SW-1:0] p_sum, p_mx, p_m2x, p_plus, p_minus;
    logic [SW-1:0]        p_mag;
    logic                 p_in0, p_in1, p_inn;

    assign p_sum   = $signed({{(SW-P){1'b0}}, pos_reg})
                   + $signed({{(SW-SPEED_W){cur_speed_reg[SPEED_W-1]}}, cur_speed_reg});
    assign p_mx    = $signed({{(SW-VW){1'b0}}, m_len});
    assign p_m2x   = $signed({p_mx[SW-2:0], 1'b0});
    assign p_plus  = p_sum + p_mx;
    assign p_minus = p_sum - p_mx;
    assign p_in0   = !p_sum[SW-1] && (p_sum < p_mx);
    assign p_in1   = !p_minus[SW-1] && (p_sum < p_m2x);
    assign p_inn   = p_sum[SW-1] && !p_plus[SW-1];
    assign p_mag   = p_sum[SW-1] ? SW'(-p_sum) : SW'(p_sum);

    always_comb begin
        div_dividend = DW'(p_mag);
        div_divisor  = m_len;
        div_start    = (state_reg == ST_POS) && !(p_in0 || p_in1 || p_inn);
    end

    // store addressing
    logic [ADDR_BITS-1:0] a_idx, b_idx;
    logic [LW-1:0]        a_inc, lp_inc;

    assign a_idx  = pos_reg[P-1:FRAC_BITS];
    assign a_inc  = {1'b0, a_idx} + LW'(1);
    assign b_idx  = (a_inc >= slen) ? '0 : a_inc[ADDR_BITS-1:0];
    assign lp_inc = {1'b0, lp_reg} + LW'(1);

    logic [SAMPLE_W-1:0] play_rdata, loop_rdata;
    logic                play_rd_en;

    assign play_rd_en = (state_reg == ST_READ_A) || (state_reg == ST_READ_B);

    vssp_store #(
        .ADDR_W(ADDR_BITS)
    ) u_play_store (
        .aclk    (aclk),
        .wr_en   (s_xfer && (in_kind == KIND_PLAY_LOAD)),
        .wr_addr (in_addr),
        .wr_data (in_sample),
        .rd_en   (play_rd_en),
        .rd_addr ((state_reg == ST_READ_B) ? b_idx : a_idx),
        .rd_data (play_rdata)
    );

    vssp_store #(
        .ADDR_W(ADDR_BITS)
    ) u_loop_store (
        .aclk    (aclk),
        .wr_en   (s_xfer && (in_kind == KIND_LOOP_LOAD)),
        .wr_addr (in_addr),
        .wr_data (in_sample),
        .rd_en   (state_reg == ST_READ_A),
        .rd_addr (lp_reg),
        .rd_data (loop_rdata)
    );

    // interpolation
    logic [FRAC_BITS-1:0] frac;
    logic [FRAC_BITS:0]   w0;
    logic signed [PW-1:0] sa_x, sb_x, w0_x, w1_x, i_sum, i_bias, i_shift;

    assign frac    = pos_reg[FRAC_BITS-1:0];
    assign w0      = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
    assign sa_x    = $signed({{(PW-SAMPLE_W){sa_reg[SAMPLE_W-1]}}, sa_reg});
    assign sb_x    = $signed({{(PW-SAMPLE_W){play_rdata[SAMPLE_W-1]}}, play_rdata});
    assign w0_x    = $signed({{(PW-FRAC_BITS-1){1'b0}}, w0});
    assign w1_x    = $signed({{(PW-FRAC_BITS){1'b0}}, frac});
    assign i_sum   = p0_reg + p1_reg;
    assign i_bias  = i_sum[PW-1] ? $signed({{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}})
                                 : '0;
    assign i_shift = (i_sum + i_bias) >>> FRAC_BITS;

    // mixing
    logic signed [MIX_W-1:0] x_res, x_loop, x_sg, x_lg, x_sum, x_bias, x_shift;
    logic signed [SAMPLE_W-1:0] x_sat;

    assign x_res   = $signed({{(MIX_W-SAMPLE_W){res_reg[SAMPLE_W-1]}}, res_reg});
    assign x_loop  = $signed({{(MIX_W-SAMPLE_W){loop_rdata[SAMPLE_W-1]}}, loop_rdata});
    assign x_sg    = $signed({{(MIX_W-GAIN_W){1'b0}}, scratch_gain_reg});
    assign x_lg    = $signed({{(MIX_W-GAIN_W){1'b0}}, loop_gain_reg});
    assign x_sum   = m0_reg + m1_reg;
    assign x_bias  = x_sum[MIX_W-1] ? $signed({{(MIX_W-GAIN_W){1'b0}}, {GAIN_W{1'b1}}})
                                    : '0;
    assign x_shift = (x_sum + x_bias) >>> GAIN_W;

    always_comb begin
        if (x_shift > $signed(MIX_W'(32767))) begin
            x_sat = 16'sh7FFF;
        end else if (x_shift < -$signed(MIX_W'(32768))) begin
            x_sat = 16'sh8000;
        end else begin
            x_sat = x_shift[SAMPLE_W-1:0];
        end
    end

    // block end
    logic [BLEN_W-1:0] bc_inc;
    logic              blk_last;
    logic              out_free;

    assign bc_inc   = {1'b0, bc_reg} + BLEN_W'(1);
    assign blk_last = (bc_inc >= blen);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cur_speed_next = cur_speed_reg;
        latched_next   = latched_reg;
        step_next      = step_reg;
        bc_next        = bc_reg;
        lp_next        = lp_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer && (in_kind == KIND_RENDER)) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (bc_reg != '0) begin
                    state_next = ST_POS;
                end else if (r_change) begin
                    latched_next = tgt_reg;
                    state_next   = ST_RDIV;
                end else begin
                    state_next = ST_RAMP;
                end
            end
            ST_RDIV: begin
                step_next  = sign_reg ? RW'(-$signed(r_quo)) : $signed(r_quo);
                state_next = ST_RAMP;
            end
            ST_RAMP: begin
                if (latched_reg != cur_speed_reg) begin
                    if (step_reg == '0) begin
                        cur_speed_next = latched_reg;
                    end else if (step_reg[RW-1] && (r_sum < r_lat)) begin
                        cur_speed_next = latched_reg;
                    end else if (!step_reg[RW-1] && (r_sum > r_lat)) begin
                        cur_speed_next = latched_reg;
                    end else begin
                        cur_speed_next = r_sum[SPEED_W-1:0];
                    end
                end
                state_next = ST_POS;
            end
            ST_POS: begin
                if (p_in0) begin
                    pos_next   = p_sum[P-1:0];
                    state_next = ST_READ_A;
                end else if (p_in1) begin
                    pos_next   = p_minus[P-1:0];
                    state_next = ST_READ_A;
                end else if (p_inn) begin
                    pos_next   = p_plus[P-1:0];
                    state_next = ST_READ_A;
                end else begin
                    state_next = ST_PDIV;
                end
            end
            ST_PDIV: begin
                if (div_done) begin
                    if (!sign_reg) begin
                        pos_next = div_rem[P-1:0];
                    end else if (div_rem == '0) begin
                        pos_next = '0;
                    end else begin
                        pos_next = P'(m_len - div_rem);
                    end
                    state_next = ST_READ_A;
                end
            end
            ST_READ_A: state_next = ST_READ_B;
            ST_READ_B: state_next = ST_MULT;
            ST_MULT:   state_next = ST_INTERP;
            ST_INTERP: state_next = mix_enable_reg ? ST_MIX : ST_OUT;
            ST_MIX:    state_next = ST_SAT;
            ST_SAT:    state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    bc_next       = blk_last ? '0 : bc_inc[BCNT_W-1:0];
                    if (mix_enable_reg) begin
                        lp_next = (lp_inc >= llen) ? '0 : lp_inc[ADDR_BITS-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            cur_speed_reg <= '0;
            latched_reg   <= '0;
            step_reg      <= '0;
            bc_reg        <= '0;
            lp_reg        <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cur_speed_reg <= cur_speed_next;
            latched_reg   <= latched_next;
            step_reg      <= step_next;
            bc_reg        <= bc_next;
            lp_reg        <= lp_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_length_reg <= SLEN_W'(65536);
            block_length_reg  <= BLEN_W'(256);
            loop_length_reg   <= SLEN_W'(65536);
            mix_enable_reg    <= 1'b0;
            scratch_gain_reg  <= GAIN_W'(32768);
            loop_gain_reg     <= GAIN_W'(32768);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SAMPLE_LENGTH: sample_length_reg <= cfg_wdata[SLEN_W-1:0];
                REG_BLOCK_LENGTH:  block_length_reg  <= cfg_wdata[BLEN_W-1:0];
                REG_LOOP_LENGTH:   loop_length_reg   <= cfg_wdata[SLEN_W-1:0];
                REG_MIX_ENABLE:    mix_enable_reg    <= cfg_wdata[0];
                REG_SCRATCH_GAIN:  scratch_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_LOOP_GAIN:     loop_gain_reg     <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            tgt_reg <= s_tdata[TARGET_LSB +: SPEED_W];
        end
        if (state_reg == ST_PREP) begin
            sign_reg <= r_diff[RW-1];
            mag_reg  <= r_mag;
        end else if (state_reg == ST_POS) begin
            sign_reg <= p_sum[SW-1];
        end
        if (state_reg == ST_READ_B) begin
            sa_reg <= play_rdata;
        end
        if (state_reg == ST_MULT) begin
            p0_reg <= sa_x * w0_x;
            p1_reg <= sb_x * w1_x;
        end
        if (state_reg == ST_INTERP) begin
            res_reg <= i_shift[SAMPLE_W-1:0];
        end
        if (state_reg == ST_MIX) begin
            m0_reg <= x_res * x_sg;
            m1_reg <= x_loop * x_lg;
        end
        if (state_reg == ST_SAT) begin
            res_reg <= x_sat;
        end
        if ((state_reg == ST_OUT) && out_free) begin
            m_tdata_reg <= res_reg;
            m_tlast_reg <= blk_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_PDIV))
        else $error("divider finished outside the wrap wait state");

    a_speed_ramp_only: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(cur_speed_reg) |-> $past(state_reg) == ST_RAMP)
        else $error("speed changed outside the ramp step");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("result not loaded into output register");

endmodule

@@ src/vssp_store.sv @@
`timescale 1ns / 1ps
// Sample store: single write port, single read port, registered read data.
// Depends on vssp_pkg for the sample width.
module vssp_store #(
    parameter int ADDR_W = 16
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [vssp_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [vssp_pkg::SAMPLE_W-1:0] rd_data
);
    import vssp_pkg::*;

    logic [SAMPLE_W-1:0] mem [2**ADDR_W];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/vssp_div.sv @@
`timescale 1ns / 1ps
// Radix-2 restoring divider, one bit per cycle, unsigned operands; only the
// remainder is kept. Used by the position wrap. No dependencies.
module vssp_div #(
    parameter int DW = 34,
    parameter int VW = 33
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [VW-1:0] remainder
);
    localparam int CNT_W = $clog2(DW + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    num_reg;
    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    dvs_reg;

    logic [VW:0] trial;
    logic [VW:0] trial_sub;
    logic        ge;

    assign trial     = {rem_reg, num_reg[DW-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign ge        = trial >= {1'b0, dvs_reg};

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            run_next = 1'b1;
            cnt_next = CNT_W'(DW);
        end else if (run_reg) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (run_reg) begin
            num_reg <= {num_reg[DW-2:0], 1'b0};
            rem_reg <= ge ? trial_sub[VW-1:0] : trial[VW-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !run_reg)
        else $error("divider restarted while busy");

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> rem_reg < dvs_reg)
        else $error("remainder not below divisor");

    a_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg |-> cnt_reg != '0)
        else $error("divider running with zero count");

endmodule

@@ tb/tb_variable_speed_sample_player_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for variable_speed_sample_player_core: directed script, then
// randomized load/render traffic with stalls, checked against an in-bench player model.
// Depends on vssp_pkg and the core RTL only.
module tb_variable_speed_sample_player_core;
    import vssp_pkg::*;

    localparam int     RAMP_STEPS    = 10;
    localparam int     FRAC_BITS     = 16;
    localparam longint FRAC_ONE      = 64'd65536;
    localparam longint STORE_DEPTH   = 64'd65536;
    localparam int     SETTLE_CYCLES = 100;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     PHASES        = 10;
    localparam int     PHASE_ITEMS   = 180;
    localparam int     MAX_REPORTS   = 10;
    localparam longint CYCLE_LIMIT   = 3_000_000;

    localparam logic [KIND_W-1:0]   KIND_UNUSED = 2'd3;
    localparam logic [SAMPLE_W-1:0] SMP_MAX     = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SMP_MIN     = 16'h8000;
    localparam logic [SPEED_W-1:0]  SPD_MAX     = 24'h7FFFFF;
    localparam logic [SPEED_W-1:0]  SPD_MIN     = 24'h800000;

    typedef struct {
        longint pos;
        longint speed;
        longint target;
        longint step;
        int     bcnt;
        int     lpos;
    } play_state_t;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } out_sample_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     wval;
        logic [KIND_W-1:0]    kind;
        logic [15:0]          addr;
        logic [SAMPLE_W-1:0]  val;
        logic [SPEED_W-1:0]   tgt;
        bit                   typed;
        logic [SAMPLE_W-1:0]  exp_sample;
        bit                   exp_last;
    } script_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [KIND_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_wdata;

    // player model
    shortint     play_mem [STORE_DEPTH];
    bit          play_set [STORE_DEPTH];
    shortint     loop_mem [STORE_DEPTH];
    bit          loop_set [STORE_DEPTH];
    play_state_t st;
    logic [16:0] reg_slen;
    logic [12:0] reg_blen;
    logic [16:0] reg_llen;
    logic        reg_mix;
    logic [15:0] reg_sgain;
    logic [15:0] reg_lgain;

    out_sample_t         owed_samples[$];
    int                  errors;
    int                  items_sent;
    int                  burst_left;
    bit                  hold_req;
    bit                  cur_typed;
    logic [SAMPLE_W-1:0] cur_exp_sample;
    bit                  cur_exp_last;
    longint              cycles;

    variable_speed_sample_player_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic longint clamp_len(longint v, longint hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // speed ramp at block start, then wrapped position step
    function automatic play_state_t advance_position(play_state_t cur, longint tgt);
        play_state_t nx;
        longint      span;
        nx = cur;
        if (nx.bcnt == 0) begin
            if (tgt != nx.target) begin
                nx.target = tgt;
                nx.step   = (nx.target - nx.speed) / RAMP_STEPS;
            end
            if (nx.target != nx.speed) begin
                if (nx.step == 0) begin
                    nx.speed = nx.target;
                end else begin
                    nx.speed += nx.step;
                    if ((nx.step < 0 && nx.speed < nx.target) ||
                        (nx.step > 0 && nx.speed > nx.target))
                        nx.speed = nx.target;
                end
            end
        end
        span   = clamp_len(longint'(reg_slen), STORE_DEPTH) * FRAC_ONE;
        nx.pos = (nx.pos + nx.speed) % span;
        if (nx.pos < 0) nx.pos += span;
        return nx;
    endfunction

    function automatic int lower_index(longint pos);
        return int'((pos >> FRAC_BITS) & (STORE_DEPTH - 1));
    endfunction

    function automatic int upper_index(int a);
        if (longint'(a) + 1 >= clamp_len(longint'(reg_slen), STORE_DEPTH)) return 0;
        return a + 1;
    endfunction

    task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t %s: expected %h got %h", $time, what, want, got);
    endtask

    always @(posedge aclk) begin : scoreboard
        play_state_t nx;
        int          a;
        int          b;
        int          waddr;
        longint      frac;
        longint      smp;
        longint      acc;
        bit          last;
        out_sample_t want;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SAMPLE_LENGTH: reg_slen  = cfg_wdata;
                    REG_BLOCK_LENGTH:  reg_blen  = cfg_wdata[12:0];
                    REG_LOOP_LENGTH:   reg_llen  = cfg_wdata;
                    REG_MIX_ENABLE:    reg_mix   = cfg_wdata[0];
                    REG_SCRATCH_GAIN:  reg_sgain = cfg_wdata[15:0];
                    REG_LOOP_GAIN:     reg_lgain = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                waddr = int'(s_tdata[ADDR_LSB +: ADDR_IN_W]);
                case (s_tuser)
                    KIND_PLAY_LOAD: begin
                        play_mem[waddr] = shortint'(s_tdata[SAMPLE_LSB +: SAMPLE_W]);
                        play_set[waddr] = 1'b1;
                    end
                    KIND_LOOP_LOAD: begin
                        loop_mem[waddr] = shortint'(s_tdata[SAMPLE_LSB +: SAMPLE_W]);
                        loop_set[waddr] = 1'b1;
                    end
                    KIND_RENDER: begin
                        nx   = advance_position(st,
                                   longint'($signed(s_tdata[TARGET_LSB +: SPEED_W])));
                        a    = lower_index(nx.pos);
                        b    = upper_index(a);
                        frac = nx.pos & (FRAC_ONE - 1);
                        smp  = (longint'(play_mem[a]) * (FRAC_ONE - frac) +
                                longint'(play_mem[b]) * frac) / FRAC_ONE;
                        if (reg_mix) begin
                            acc = (smp * longint'(reg_sgain) +
                                   longint'(loop_mem[st.lpos]) * longint'(reg_lgain)) / 65536;
                            if (acc > 32767) acc = 32767;
                            if (acc < -32768) acc = -32768;
                            smp = acc;
                            nx.lpos = st.lpos + 1;
                            if (longint'(nx.lpos) >= clamp_len(longint'(reg_llen), STORE_DEPTH))
                                nx.lpos = 0;
                        end
                        if (longint'(nx.bcnt) + 1 >= clamp_len(longint'(reg_blen), 4096)) begin
                            last    = 1'b1;
                            nx.bcnt = 0;
                        end else begin
                            last    = 1'b0;
                            nx.bcnt = nx.bcnt + 1;
                        end
                        st = nx;
                        if (cur_typed) begin
                            want.sample = cur_exp_sample;
                            want.last   = cur_exp_last;
                        end else begin
                            want.sample = smp[15:0];
                            want.last   = last;
                        end
                        owed_samples.push_back(want);
                    end
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (owed_samples.size() == 0) begin
                    note_mismatch("result with none outstanding", '0, m_tdata);
                end else begin
                    want = owed_samples.pop_front();
                    if (m_tdata !== want.sample)
                        note_mismatch("out_sample", want.sample, m_tdata);
                    if (m_tlast !== want.last)
                        note_mismatch("block_last", 16'(want.last), 16'(m_tlast));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: segments of steady, random and sparse ready, plus one long hold
    initial begin : receiver
        int mode;
        int len;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            mode = $urandom_range(0, 2);
            len  = $urandom_range(5, 60);
            repeat (len) begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(negedge aclk);
            end
        end
    end

    // tasks below start and end on a falling edge
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [15:0] addr,
                             input logic [SAMPLE_W-1:0] val, input logic [SPEED_W-1:0] tgt,
                             input bit typed = 1'b0, input logic [SAMPLE_W-1:0] es = '0,
                             input bit el = 1'b0);
        int gap;
        s_tvalid       <= 1'b1;
        s_tuser        <= kind;
        s_tdata        <= {tgt, val, addr};
        cur_typed      = typed;
        cur_exp_sample = es;
        cur_exp_last   = el;
        do @(posedge aclk); while (!s_tready);
        if (kind != KIND_UNUSED) items_sent++;
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
    endtask

    // loads any store entry the render will read but that was never written
    task automatic render_item(input logic [SPEED_W-1:0] tgt, input bit typed = 1'b0,
                               input logic [SAMPLE_W-1:0] es = '0, input bit el = 1'b0);
        play_state_t nx;
        int          a;
        int          b;
        int          lp;
        bit          mix_on;
        nx     = advance_position(st, longint'($signed(tgt)));
        a      = lower_index(nx.pos);
        b      = upper_index(a);
        lp     = st.lpos;
        mix_on = reg_mix;
        if (!play_set[a])
            send_item(KIND_PLAY_LOAD, 16'(a), 16'($urandom()), 24'($urandom()));
        if (b != a && !play_set[b])
            send_item(KIND_PLAY_LOAD, 16'(b), 16'($urandom()), 24'($urandom()));
        if (mix_on && !loop_set[lp])
            send_item(KIND_LOOP_LOAD, 16'(lp), 16'($urandom()), 24'($urandom()));
        send_item(KIND_RENDER, 16'($urandom()), 16'($urandom()), tgt, typed, es, el);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (owed_samples.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [CFG_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 17'd1;
            1:       return 17'd65536;
            2:       return 17'($urandom_range(0, 131071));
            default: return 17'($urandom_range(2, 64));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 17'd0;
            1:       return 17'd65535;
            2:       return 17'd32768;
            default: return 17'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [SPEED_W-1:0] pick_target();
        case ($urandom_range(0, 9))
            0, 1, 2: return 24'(st.target);
            3, 4:    return 24'(st.speed + longint'($urandom_range(0, 18)) - 9);
            5, 6, 7: return 24'(longint'($urandom_range(0, 524288)) - 262144);
            8:       return 24'($urandom());
            default: begin
                case ($urandom_range(0, 3))
                    0:       return SPD_MAX;
                    1:       return SPD_MIN;
                    2:       return 24'h000000;
                    default: return 24'h010000;
                endcase
            end
        endcase
    endfunction

    task automatic random_item();
        int          r;
        logic [15:0] addr;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            send_item(KIND_UNUSED, 16'($urandom()), 16'($urandom()), 24'($urandom()));
        end else if (r < 23) begin
            addr = $urandom_range(0, 1) ? 16'($urandom())
                 : 16'($urandom_range(0, int'(clamp_len(longint'(reg_slen), STORE_DEPTH)) - 1));
            send_item(KIND_PLAY_LOAD, addr, 16'($urandom()), 24'($urandom()));
        end else if (r < 33) begin
            addr = $urandom_range(0, 1) ? 16'($urandom())
                 : 16'($urandom_range(0, int'(clamp_len(longint'(reg_llen), STORE_DEPTH)) - 1));
            send_item(KIND_LOOP_LOAD, addr, 16'($urandom()), 24'($urandom()));
        end else begin
            render_item(pick_target());
        end
    endtask

    function automatic script_row_t item_row(logic [KIND_W-1:0] kind, logic [15:0] addr,
                                             logic [SAMPLE_W-1:0] val,
                                             logic [SPEED_W-1:0] tgt);
        script_row_t row;
        row      = '{default: '0};
        row.kind = kind;
        row.addr = addr;
        row.val  = val;
        row.tgt  = tgt;
        return row;
    endfunction

    function automatic script_row_t checked_row(logic [SPEED_W-1:0] tgt,
                                                logic [SAMPLE_W-1:0] es, bit el);
        script_row_t row;
        row            = item_row(KIND_RENDER, '0, '0, tgt);
        row.typed      = 1'b1;
        row.exp_sample = es;
        row.exp_last   = el;
        return row;
    endfunction

    function automatic script_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        script_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.wval   = v;
        return row;
    endfunction

    initial begin : stimulus
        script_row_t script[$];
        bit          in_cfg;
        int          goal;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_PLAY_LOAD;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_SAMPLE_LENGTH;
        cfg_wdata  = '0;
        errors     = 0;
        items_sent = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        cur_typed  = 1'b0;
        cycles     = 0;
        st         = '{default: 0};
        reg_slen   = 17'd65536;
        reg_blen   = 13'd256;
        reg_llen   = 17'd65536;
        reg_mix    = 1'b0;
        reg_sgain  = 16'd32768;
        reg_lgain  = 16'd32768;

        // reset defaults: speed 0, position 0, block of 256
        script.push_back(item_row(KIND_PLAY_LOAD, 16'd0, SMP_MAX, '0));
        script.push_back(item_row(KIND_PLAY_LOAD, 16'd1, SMP_MIN, '0));
        script.push_back(item_row(KIND_PLAY_LOAD, 16'hFFFF, 16'h1234, SPD_MAX));
        script.push_back(item_row(KIND_LOOP_LOAD, 16'd0, SMP_MIN, '0));
        script.push_back(item_row(KIND_LOOP_LOAD, 16'hFFFF, SMP_MAX, SPD_MIN));
        script.push_back(checked_row(24'd0, SMP_MAX, 1'b0));
        // unknown kind must not touch the play store
        script.push_back(item_row(KIND_UNUSED, 16'd0, 16'h0005, SPD_MAX));
        // mid-block: target ignored
        script.push_back(checked_row(SPD_MAX, SMP_MAX, 1'b0));
        // full-scale ramps over a two-sample store, mixed at max gain
        script.push_back(cfg_row(REG_BLOCK_LENGTH, 17'd1));
        script.push_back(cfg_row(REG_SAMPLE_LENGTH, 17'd2));
        script.push_back(cfg_row(REG_LOOP_LENGTH, 17'd1));
        script.push_back(cfg_row(REG_MIX_ENABLE, 17'd1));
        script.push_back(cfg_row(REG_SCRATCH_GAIN, 17'd65535));
        script.push_back(cfg_row(REG_LOOP_GAIN, 17'd65535));
        script.push_back(item_row(KIND_RENDER, '0, '0, SPD_MAX));
        script.push_back(item_row(KIND_RENDER, '0, '0, SPD_MIN));
        script.push_back(item_row(KIND_RENDER, '0, '0, SPD_MIN));
        // zero gains mute the mix
        script.push_back(cfg_row(REG_SCRATCH_GAIN, 17'd0));
        script.push_back(cfg_row(REG_LOOP_GAIN, 17'd0));
        script.push_back(checked_row(SPD_MIN, 16'd0, 1'b1));
        // positive saturation
        script.push_back(item_row(KIND_PLAY_LOAD, 16'd0, SMP_MAX, '0));
        script.push_back(item_row(KIND_PLAY_LOAD, 16'd1, SMP_MAX, '0));
        script.push_back(item_row(KIND_LOOP_LOAD, 16'd0, SMP_MAX, '0));
        script.push_back(cfg_row(REG_SCRATCH_GAIN, 17'd65535));
        script.push_back(cfg_row(REG_LOOP_GAIN, 17'd65535));
        script.push_back(checked_row(24'd0, SMP_MAX, 1'b1));
        // zero lengths clamp to one
        script.push_back(cfg_row(REG_MIX_ENABLE, 17'd0));
        script.push_back(cfg_row(REG_SAMPLE_LENGTH, 17'd0));
        script.push_back(cfg_row(REG_BLOCK_LENGTH, 17'd0));
        script.push_back(cfg_row(REG_LOOP_LENGTH, 17'd0));
        script.push_back(checked_row(SPD_MAX, SMP_MAX, 1'b1));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        in_cfg = 1'b0;
        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                if (!in_cfg) quiesce();
                in_cfg = 1'b1;
                cfg_write(script[i].idx, script[i].wval);
            end else begin
                in_cfg = 1'b0;
                if (script[i].kind == KIND_RENDER)
                    render_item(script[i].tgt, script[i].typed, script[i].exp_sample,
                                script[i].exp_last);
                else
                    send_item(script[i].kind, script[i].addr, script[i].val, script[i].tgt);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            quiesce();
            case (p)
                0: begin
                    cfg_write(REG_SAMPLE_LENGTH, 17'd65536);
                    cfg_write(REG_BLOCK_LENGTH, 17'd4096);
                    cfg_write(REG_LOOP_LENGTH, 17'd65536);
                    cfg_write(REG_MIX_ENABLE, 17'd1);
                    cfg_write(REG_SCRATCH_GAIN, 17'd65535);
                    cfg_write(REG_LOOP_GAIN, 17'd65535);
                end
                1: begin
                    cfg_write(REG_SAMPLE_LENGTH, 17'd1);
                    cfg_write(REG_BLOCK_LENGTH, 17'd1);
                    cfg_write(REG_LOOP_LENGTH, 17'd1);
                    cfg_write(REG_MIX_ENABLE, 17'd1);
                    cfg_write(REG_SCRATCH_GAIN, 17'd65535);
                    cfg_write(REG_LOOP_GAIN, 17'd0);
                end
                default: begin
                    cfg_write(REG_SAMPLE_LENGTH, pick_length());
                    case ($urandom_range(0, 7))
                        0:       cfg_write(REG_BLOCK_LENGTH, 17'd1);
                        1:       cfg_write(REG_BLOCK_LENGTH, 17'($urandom_range(0, 8191)));
                        default: cfg_write(REG_BLOCK_LENGTH, 17'($urandom_range(2, 24)));
                    endcase
                    cfg_write(REG_LOOP_LENGTH, pick_length());
                    cfg_write(REG_MIX_ENABLE, 17'($urandom_range(0, 1)));
                    cfg_write(REG_SCRATCH_GAIN, pick_gain());
                    cfg_write(REG_LOOP_GAIN, pick_gain());
                end
            endcase
            if (p == 3) hold_req = 1'b1;
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) random_item();
        end

        quiesce();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
